// ----- rtl/srle_pkg.sv -----
// Shared types and constants for the snapshot run-length page decoder.
// No dependencies; imported by every module of the block.
package srle_pkg;

    localparam logic [7:0] SEQ_BYTE = 8'hED;

    localparam logic [15:0] BASE_PAGE0 = 16'h4000;
    localparam logic [15:0] BASE_PAGE1 = 16'h8000;
    localparam logic [15:0] BASE_PAGE2 = 16'hC000;

    localparam logic [1:0] PAGE_CODE0 = 2'd0;
    localparam logic [1:0] PAGE_CODE1 = 2'd1;
    localparam logic [1:0] PAGE_CODE2 = 2'd2;
    localparam logic [1:0] PAGE_CODE_BAD = 2'd3;

    localparam int NUM_SLOTS = 4;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    typedef struct packed {
        logic [15:0]               addr;
        logic [NUM_SLOTS-1:0][7:0] vals;
        logic [7:0]                len0;
        logic [1:0]                last_idx;
    } srle_entry_t;

    typedef struct packed {
        logic push;
        logic full;
        logic pop;
        logic empty;
    } srle_qctl_t;

endpackage

// ----- rtl/srle_front.sv -----
// Front end: accepts data bytes, runs the escape phase machine and builds one
// queue entry of up to four writes per byte. Depends on srle_pkg.
module srle_front
    import srle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_block_start,
    input  logic [1:0]  s_page_code,
    input  logic        s_compressed,
    input  logic        s_block_end,
    input  logic        q_full,
    output logic        q_push,
    output srle_entry_t q_entry
);

    localparam logic [2:0] PH_LIT = 3'd0;
    localparam logic [2:0] PH_Z   = 3'd1;
    localparam logic [2:0] PH_ZE  = 3'd2;
    localparam logic [2:0] PH_ZEE = 3'd3;
    localparam logic [2:0] PH_E   = 3'd4;
    localparam logic [2:0] PH_EE  = 3'd5;
    localparam logic [2:0] PH_EEN = 3'd6;

    logic [15:0] addr_reg, addr_next;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    logic        mode_reg, mode_next;
    logic        fin_reg, fin_next;

    logic [15:0] st_addr;
    logic [2:0]  st_phase;
    logic [7:0]  st_held;
    logic        st_fin;

    logic [3:0][7:0] dv, fv;
    logic [1:0]      dn, fn;
    logic [7:0]      len0;
    logic [2:0]      total;
    logic            fresh_emit;
    logic [2:0]      fresh_ph;
    logic            accept;

    assign s_ready = !q_full;
    assign accept = s_valid && s_ready;

    always_comb begin
        st_addr  = addr_reg;
        st_phase = phase_reg;
        st_held  = held_reg;
        st_fin   = fin_reg;
        mode_next = mode_reg;
        if (s_block_start) begin
            case (s_page_code)
                PAGE_CODE1: st_addr = BASE_PAGE1;
                PAGE_CODE2: st_addr = BASE_PAGE2;
                default:    st_addr = BASE_PAGE0;
            endcase
            st_phase = PH_LIT;
            st_held = 8'd0;
            mode_next = s_compressed;
            st_fin = (s_page_code == PAGE_CODE_BAD);
        end

        fresh_emit = (s_data_byte != 8'h00) && (s_data_byte != SEQ_BYTE);
        if (s_data_byte == 8'h00) begin
            fresh_ph = PH_Z;
        end else if (s_data_byte == SEQ_BYTE) begin
            fresh_ph = PH_E;
        end else begin
            fresh_ph = PH_LIT;
        end

        dv = '0;
        dn = 2'd0;
        len0 = 8'd1;
        phase_next = st_phase;
        held_next = st_held;
        fin_next = st_fin;

        if (!st_fin) begin
            if (mode_next) begin
                case (st_phase)
                    PH_Z: begin
                        if (s_data_byte == SEQ_BYTE) begin
                            phase_next = PH_ZE;
                        end else begin
                            dv[0] = 8'h00;
                            dv[1] = s_data_byte;
                            dn = fresh_emit ? 2'd2 : 2'd1;
                            phase_next = fresh_ph;
                        end
                    end
                    PH_ZE: begin
                        if (s_data_byte == SEQ_BYTE) begin
                            phase_next = PH_ZEE;
                        end else begin
                            dv[0] = 8'h00;
                            dv[1] = SEQ_BYTE;
                            dv[2] = s_data_byte;
                            dn = fresh_emit ? 2'd3 : 2'd2;
                            phase_next = fresh_ph;
                        end
                    end
                    PH_ZEE: begin
                        if (s_data_byte == 8'h00) begin
                            phase_next = PH_LIT;
                            fin_next = 1'b1;
                        end else begin
                            dv[0] = 8'h00;
                            dn = 2'd1;
                            held_next = s_data_byte;
                            phase_next = PH_EEN;
                        end
                    end
                    PH_E: begin
                        if (s_data_byte == SEQ_BYTE) begin
                            phase_next = PH_EE;
                        end else begin
                            dv[0] = SEQ_BYTE;
                            dv[1] = s_data_byte;
                            dn = fresh_emit ? 2'd2 : 2'd1;
                            phase_next = fresh_ph;
                        end
                    end
                    PH_EE: begin
                        held_next = s_data_byte;
                        phase_next = PH_EEN;
                    end
                    PH_EEN: begin
                        dv[0] = s_data_byte;
                        dn = (st_held != 8'd0) ? 2'd1 : 2'd0;
                        len0 = st_held;
                        held_next = 8'd0;
                        phase_next = PH_LIT;
                    end
                    default: begin
                        dv[0] = s_data_byte;
                        dn = fresh_emit ? 2'd1 : 2'd0;
                        phase_next = fresh_ph;
                    end
                endcase
            end else begin
                dv[0] = s_data_byte;
                dn = 2'd1;
            end
        end

        fv = '0;
        fn = 2'd0;
        if (!st_fin && s_block_end) begin
            case (phase_next)
                PH_Z: begin
                    fv[0] = 8'h00;
                    fn = 2'd1;
                end
                PH_ZE: begin
                    fv[0] = 8'h00;
                    fv[1] = SEQ_BYTE;
                    fn = 2'd2;
                end
                PH_ZEE: begin
                    fv[0] = 8'h00;
                    fv[1] = SEQ_BYTE;
                    fv[2] = SEQ_BYTE;
                    fn = 2'd3;
                end
                PH_E: begin
                    fv[0] = SEQ_BYTE;
                    fn = 2'd1;
                end
                PH_EE: begin
                    fv[0] = SEQ_BYTE;
                    fv[1] = SEQ_BYTE;
                    fn = 2'd2;
                end
                PH_EEN: begin
                    fv[0] = SEQ_BYTE;
                    fv[1] = SEQ_BYTE;
                    fv[2] = held_next;
                    fn = 2'd3;
                end
                default: fn = 2'd0;
            endcase
            phase_next = PH_LIT;
            held_next = 8'd0;
            fin_next = 1'b1;
        end

        total = {1'b0, dn} + {1'b0, fn};
        if (total > 3'd4) begin
            total = 3'd4;
        end

        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (i < int'(dn)) begin
                q_entry.vals[i] = dv[i];
            end else begin
                q_entry.vals[i] = fv[2'(i - int'(dn))];
            end
        end
        q_entry.addr = st_addr;
        q_entry.len0 = len0;
        q_entry.last_idx = 2'(total - 3'd1);

        if (total != 3'd0) begin
            addr_next = st_addr + {8'd0, len0} + {13'd0, total} - 16'd1;
        end else begin
            addr_next = st_addr;
        end
    end

    assign q_push = accept && (total != 3'd0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg  <= BASE_PAGE0;
            phase_reg <= PH_LIT;
            held_reg  <= 8'd0;
            mode_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end else if (accept) begin
            addr_reg  <= addr_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            mode_reg  <= mode_next;
            fin_reg   <= fin_next;
        end
    end

endmodule

// ----- rtl/srle_queue.sv -----
// Short queue of decoded write entries between front and back end.
// Depends on srle_pkg for the entry type and depth.
module srle_queue
    import srle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  srle_qctl_t  ctl_in,
    output srle_qctl_t  ctl_out,
    input  srle_entry_t wr_entry,
    output srle_entry_t rd_entry
);

    srle_entry_t mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push, do_pop;

    assign ctl_out.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign ctl_out.empty = (count_reg == '0);
    assign ctl_out.push  = do_push;
    assign ctl_out.pop   = do_pop;
    assign do_push = ctl_in.push && !ctl_out.full;
    assign do_pop  = ctl_in.pop && !ctl_out.empty;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- rtl/srle_back.sv -----
// Back end: expands each queue entry into write-run beats on the result
// channel through an output register. Depends on srle_pkg.
module srle_back
    import srle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  srle_qctl_t  q_status,
    input  srle_entry_t q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_write_address,
    output logic [7:0]  m_write_value,
    output logic [7:0]  m_run_length,
    output logic        m_last_of_item
);

    logic        valid_reg;
    logic [15:0] addr_reg;
    logic [7:0]  value_reg;
    logic [7:0]  len_reg;
    logic        last_reg;
    logic [1:0]  idx_reg, idx_next;
    logic        load, take, slot_last;

    assign load = !valid_reg || m_ready;
    assign take = load && !q_status.empty;
    assign slot_last = (idx_reg == q_head.last_idx);
    assign q_pop = take && slot_last;
    assign idx_next = slot_last ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= !q_status.empty;
            if (take) begin
                idx_reg <= idx_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            addr_reg  <= q_head.addr + {14'd0, idx_reg};
            value_reg <= q_head.vals[idx_reg];
            len_reg   <= (idx_reg == 2'd0) ? q_head.len0 : 8'd1;
            last_reg  <= slot_last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_write_address = addr_reg;
    assign m_write_value   = value_reg;
    assign m_run_length    = len_reg;
    assign m_last_of_item  = last_reg;

endmodule

// ----- rtl/snapshot_rle_page_decoder.sv -----
// Top level of the snapshot run-length page decoder: front end, entry queue
// and back end. Depends on srle_pkg, srle_front, srle_queue and srle_back.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid / s_ready  data_byte, block_start, page_code,
//                                    compressed, block_end
//   m_       out  m_valid / m_ready  write_address, write_value,
//                                    run_length, last_of_item
//
// One data byte is accepted per cycle while the four-entry queue has room.
// Each byte yields zero to four write runs; the back end sends one run per
// cycle while m_ready is high, so the runs of one byte leave one by one.
// A run goes from the front decode into the queue and then through the
// output register to m_. Synchronous active-low reset empties the queue
// and sets the decoder to a raw block at 0x4000. Stalls on m_ fill the
// queue before s_ready drops.
module snapshot_rle_page_decoder
    import srle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_block_start,
    input  logic [1:0]  s_page_code,
    input  logic        s_compressed,
    input  logic        s_block_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_write_address,
    output logic [7:0]  m_write_value,
    output logic [7:0]  m_run_length,
    output logic        m_last_of_item
);

    srle_entry_t push_entry, head_entry;
    srle_qctl_t  q_req, q_stat;
    logic        push, pop;

    assign q_req.push  = push;
    assign q_req.pop   = pop;
    assign q_req.full  = 1'b0;
    assign q_req.empty = 1'b0;

    srle_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_block_start (s_block_start),
        .s_page_code   (s_page_code),
        .s_compressed  (s_compressed),
        .s_block_end   (s_block_end),
        .q_full        (q_stat.full),
        .q_push        (push),
        .q_entry       (push_entry)
    );

    srle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl_in   (q_req),
        .ctl_out  (q_stat),
        .wr_entry (push_entry),
        .rd_entry (head_entry)
    );

    srle_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_status        (q_stat),
        .q_head          (head_entry),
        .q_pop           (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_value   (m_write_value),
        .m_run_length    (m_run_length),
        .m_last_of_item  (m_last_of_item)
    );

endmodule

// ----- test/srle_run_checker.sv -----
// Checker for the snapshot run-length page decoder: predicts the write runs of every
// accepted input beat and compares each accepted output beat in order.
// Depends on srle_pkg for the sequence byte, page codes and page base addresses.
module srle_run_checker
    import srle_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_block_start,
    input  logic [1:0]  s_page_code,
    input  logic        s_compressed,
    input  logic        s_block_end,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_write_address,
    input  logic [7:0]  m_write_value,
    input  logic [7:0]  m_run_length,
    input  logic        m_last_of_item,
    output int          errors,
    output int          runs_pending,
    output int          runs_seen,
    output int          live_beats
);

    localparam logic [2:0] DP_LIT = 3'd0;
    localparam logic [2:0] DP_Z   = 3'd1;
    localparam logic [2:0] DP_ZE  = 3'd2;
    localparam logic [2:0] DP_ZEE = 3'd3;
    localparam logic [2:0] DP_E   = 3'd4;
    localparam logic [2:0] DP_EE  = 3'd5;
    localparam logic [2:0] DP_EEN = 3'd6;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  val;
        logic [7:0]  len;
        logic        last;
    } wr_run_t;

    logic [15:0] nxt_addr = BASE_PAGE0;
    logic [2:0]  phase = DP_LIT;
    logic [7:0]  held_n = 8'h00;
    logic        comp_mode = 1'b0;
    logic        finished = 1'b0;

    wr_run_t beat_runs[$];
    wr_run_t runs_due[$];
    int      err_count = 0;
    int      seen_count = 0;
    int      live_count = 0;

    function automatic void put_run(input logic [7:0] v, input logic [7:0] n);
        wr_run_t r;
        if (n != 8'h00 && beat_runs.size() < NUM_SLOTS) begin
            r.addr = nxt_addr;
            r.val = v;
            r.len = n;
            r.last = 1'b0;
            beat_runs.push_back(r);
            nxt_addr = nxt_addr + {8'h00, n};
        end
    endfunction

    function automatic logic [2:0] take_fresh(input logic [7:0] b);
        if (b == 8'h00) begin
            return DP_Z;
        end
        if (b == SEQ_BYTE) begin
            return DP_E;
        end
        put_run(b, 8'd1);
        return DP_LIT;
    endfunction

    function automatic void decode_beat(input logic [7:0] b, input logic st,
                                        input logic [1:0] pg, input logic cp,
                                        input logic en);
        wr_run_t r;
        beat_runs.delete();
        if (st) begin
            case (pg)
                PAGE_CODE1: nxt_addr = BASE_PAGE1;
                PAGE_CODE2: nxt_addr = BASE_PAGE2;
                default:    nxt_addr = BASE_PAGE0;
            endcase
            phase = DP_LIT;
            held_n = 8'h00;
            comp_mode = cp;
            finished = (pg == PAGE_CODE_BAD);
        end
        if (!finished) begin
            live_count++;
            if (!comp_mode) begin
                put_run(b, 8'd1);
            end else begin
                case (phase)
                    DP_Z: begin
                        if (b == SEQ_BYTE) begin
                            phase = DP_ZE;
                        end else begin
                            put_run(8'h00, 8'd1);
                            phase = take_fresh(b);
                        end
                    end
                    DP_ZE: begin
                        if (b == SEQ_BYTE) begin
                            phase = DP_ZEE;
                        end else begin
                            put_run(8'h00, 8'd1);
                            put_run(SEQ_BYTE, 8'd1);
                            phase = take_fresh(b);
                        end
                    end
                    DP_ZEE: begin
                        if (b == 8'h00) begin
                            phase = DP_LIT;
                            finished = 1'b1;
                        end else begin
                            put_run(8'h00, 8'd1);
                            held_n = b;
                            phase = DP_EEN;
                        end
                    end
                    DP_E: begin
                        if (b == SEQ_BYTE) begin
                            phase = DP_EE;
                        end else begin
                            put_run(SEQ_BYTE, 8'd1);
                            phase = take_fresh(b);
                        end
                    end
                    DP_EE: begin
                        held_n = b;
                        phase = DP_EEN;
                    end
                    DP_EEN: begin
                        put_run(b, held_n);
                        held_n = 8'h00;
                        phase = DP_LIT;
                    end
                    default: phase = take_fresh(b);
                endcase
            end
            if (en) begin
                if (!finished) begin
                    // flush held bytes as literals
                    case (phase)
                        DP_Z: put_run(8'h00, 8'd1);
                        DP_ZE: begin
                            put_run(8'h00, 8'd1);
                            put_run(SEQ_BYTE, 8'd1);
                        end
                        DP_ZEE: begin
                            put_run(8'h00, 8'd1);
                            put_run(SEQ_BYTE, 8'd1);
                            put_run(SEQ_BYTE, 8'd1);
                        end
                        DP_E: put_run(SEQ_BYTE, 8'd1);
                        DP_EE: begin
                            put_run(SEQ_BYTE, 8'd1);
                            put_run(SEQ_BYTE, 8'd1);
                        end
                        DP_EEN: begin
                            put_run(SEQ_BYTE, 8'd1);
                            put_run(SEQ_BYTE, 8'd1);
                            put_run(held_n, 8'd1);
                        end
                        default: ;
                    endcase
                    phase = DP_LIT;
                    held_n = 8'h00;
                end
                finished = 1'b1;
            end
        end
        foreach (beat_runs[i]) begin
            r = beat_runs[i];
            r.last = (i == beat_runs.size() - 1);
            runs_due.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin : watch
        wr_run_t exp_run;
        if (!aresetn) begin
            nxt_addr = BASE_PAGE0;
            phase = DP_LIT;
            held_n = 8'h00;
            comp_mode = 1'b0;
            finished = 1'b0;
            runs_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen_count++;
                if (runs_due.size() == 0) begin
                    err_count++;
                    $display("%0t: expected no run, got addr %h value %h len %0d last %b",
                             $time, m_write_address, m_write_value, m_run_length,
                             m_last_of_item);
                end else begin
                    exp_run = runs_due.pop_front();
                    if (m_write_address !== exp_run.addr) begin
                        err_count++;
                        $display("%0t: write_address expected %h got %h",
                                 $time, exp_run.addr, m_write_address);
                    end
                    if (m_write_value !== exp_run.val) begin
                        err_count++;
                        $display("%0t: write_value expected %h got %h",
                                 $time, exp_run.val, m_write_value);
                    end
                    if (m_run_length !== exp_run.len) begin
                        err_count++;
                        $display("%0t: run_length expected %0d got %0d",
                                 $time, exp_run.len, m_run_length);
                    end
                    if (m_last_of_item !== exp_run.last) begin
                        err_count++;
                        $display("%0t: last_of_item expected %b got %b",
                                 $time, exp_run.last, m_last_of_item);
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_beat(s_data_byte, s_block_start, s_page_code, s_compressed,
                            s_block_end);
            end
        end
        errors <= err_count;
        runs_pending <= runs_due.size();
        runs_seen <= seen_count;
        live_beats <= live_count;
    end

endmodule

// ----- test/testbench.sv -----
// Top of the page decoder regression: clock, reset, byte-stream stimulus and output
// back-pressure, with srle_run_checker beside the block for prediction and compare.
// Depends on srle_pkg, snapshot_rle_page_decoder and srle_run_checker.
module testbench;
    import srle_pkg::*;

    localparam int LIMIT_CYCLES = 100000;
    localparam int HOLD_CYCLES = 300;
    localparam int TARGET_BEATS = 480;
    localparam int DRAIN_CYCLES = 16;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_block_start = 1'b0;
    logic [1:0]  s_page_code = PAGE_CODE0;
    logic        s_compressed = 1'b0;
    logic        s_block_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_write_address;
    logic [7:0]  m_write_value;
    logic [7:0]  m_run_length;
    logic        m_last_of_item;

    logic calm = 1'b0;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   block_count = 0;
    int   errors;
    int   runs_pending;
    int   runs_seen;
    int   live_beats;

    snapshot_rle_page_decoder dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_block_start   (s_block_start),
        .s_page_code     (s_page_code),
        .s_compressed    (s_compressed),
        .s_block_end     (s_block_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_value   (m_write_value),
        .m_run_length    (m_run_length),
        .m_last_of_item  (m_last_of_item)
    );

    srle_run_checker watch (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_block_start   (s_block_start),
        .s_page_code     (s_page_code),
        .s_compressed    (s_compressed),
        .s_block_end     (s_block_end),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_address (m_write_address),
        .m_write_value   (m_write_value),
        .m_run_length    (m_run_length),
        .m_last_of_item  (m_last_of_item),
        .errors          (errors),
        .runs_pending    (runs_pending),
        .runs_seen       (runs_seen),
        .live_beats      (live_beats)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_ready <= 1'b0;
                hold_left = HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left--;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 12);
            end
        end
    end

    task automatic send_beat(input logic [7:0] d, input logic st, input logic [1:0] pg,
                             input logic cp, input logic en);
        while (!calm && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_block_start <= st;
        s_page_code <= pg;
        s_compressed <= cp;
        s_block_end <= en;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_runs();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (runs_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic play_block(input logic wrap);
        logic [7:0] body[$];
        logic [7:0] n;
        logic [1:0] pg;
        logic       cp;
        logic       st;
        logic       en;
        logic       flag_end;
        int         ntok;
        int         ending;
        int         last;
        if (wrap) begin
            // enough full-length runs from the top page to cross 0xFFFF
            pg = PAGE_CODE2;
            cp = 1'b1;
            repeat (66) begin
                body.push_back(SEQ_BYTE);
                body.push_back(SEQ_BYTE);
                body.push_back(8'hFF);
                body.push_back(8'($urandom_range(255)));
            end
            flag_end = 1'b1;
        end else begin
            pg = ($urandom_range(99) < 8) ? PAGE_CODE_BAD : 2'($urandom_range(2));
            cp = ($urandom_range(99) < 75);
            ntok = $urandom_range(12, 1);
            repeat (ntok) begin
                case ($urandom_range(9))
                    0, 1, 2: body.push_back(8'($urandom_range(255)));
                    3, 4: begin
                        case ($urandom_range(3))
                            0:       n = 8'h00;
                            1:       n = 8'h01;
                            2:       n = 8'hFF;
                            default: n = 8'($urandom_range(255));
                        endcase
                        body.push_back(SEQ_BYTE);
                        body.push_back(SEQ_BYTE);
                        body.push_back(n);
                        body.push_back(8'($urandom_range(255)));
                    end
                    5: begin
                        body.push_back(8'h00);
                        body.push_back(8'($urandom_range(255)));
                    end
                    6: begin
                        body.push_back(SEQ_BYTE);
                        body.push_back(8'($urandom_range(255)));
                    end
                    7: begin
                        body.push_back(8'h00);
                        body.push_back(SEQ_BYTE);
                        body.push_back(SEQ_BYTE);
                        body.push_back(8'($urandom_range(255, 1)));
                        body.push_back(8'($urandom_range(255)));
                    end
                    8: begin
                        body.push_back(8'h00);
                        body.push_back(SEQ_BYTE);
                        body.push_back(8'($urandom_range(255)));
                    end
                    default: body.push_back($urandom_range(1) ? SEQ_BYTE : 8'h00);
                endcase
            end
            ending = $urandom_range(9);
            flag_end = (ending < 6);
            if (ending == 6 || ending == 7) begin
                body.push_back(8'h00);
                body.push_back(SEQ_BYTE);
                body.push_back(SEQ_BYTE);
                body.push_back(8'h00);
                repeat ($urandom_range(3)) body.push_back(8'($urandom_range(255)));
            end
        end
        last = body.size() - 1;
        foreach (body[i]) begin
            st = (i == 0);
            en = flag_end && (i == last);
            if (!wrap && $urandom_range(99) < 4) begin
                st = 1'($urandom_range(1));
                en = 1'($urandom_range(1));
            end
            send_beat(body[i], st, st ? pg : 2'($urandom_range(3)),
                      st ? cp : 1'($urandom_range(1)), en);
        end
        block_count++;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // raw bytes before any block start
        send_beat(8'h00, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        // full-length run, then a zero-count run
        send_beat(SEQ_BYTE, 1'b1, PAGE_CODE1, 1'b1, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'hAA, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'h55, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        // near-marker that turns into a literal zero and a run
        send_beat(8'h00, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'h05, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'h11, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        // end marker, then a byte that must be dropped
        send_beat(8'h00, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'h00, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'h77, 1'b0, PAGE_CODE2, 1'b1, 1'b0);
        // bad page code discards the block
        send_beat(8'h12, 1'b1, PAGE_CODE_BAD, 1'b1, 1'b0);
        // block end on a pending count flushes four runs from one beat
        send_beat(8'h00, 1'b1, PAGE_CODE0, 1'b1, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(SEQ_BYTE, 1'b0, PAGE_CODE0, 1'b0, 1'b0);
        send_beat(8'h09, 1'b0, PAGE_CODE0, 1'b0, 1'b1);
        // one-byte raw block
        send_beat(8'hFF, 1'b1, PAGE_CODE2, 1'b0, 1'b1);
        drain_runs();

        while (live_beats < TARGET_BEATS) begin
            calm <= (block_count >= 12 && block_count < 24);
            if (block_count == 5) begin
                hold_req <= 1'b1;
            end
            if (block_count == 8) begin
                drain_runs();
            end
            play_block(block_count == 5);
        end
        drain_runs();
        @(negedge aclk);

        $display("Covered %0d blocks, %0d decoded bytes and %0d checked write runs,",
                 block_count, live_beats, runs_seen);
        $display("with an address wrap, a long output hold and a full drain mid-run.");
        if (errors == 0 && runs_pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/srle_pkg.sv
rtl/srle_front.sv
rtl/srle_queue.sv
rtl/srle_back.sv
rtl/snapshot_rle_page_decoder.sv
test/srle_run_checker.sv
test/testbench.sv
